### design/drc_pkg.sv
`timescale 1ns / 1ps
package drc_pkg;

  localparam int unsigned DIST_W   = 16;
  localparam int unsigned COUNT_W  = 8;
  localparam int unsigned MAXD_W   = 14;
  localparam int unsigned POWER_W  = 7;
  localparam int unsigned LEVEL_W  = 8;

  // index divider: numerator (d << 8) + (s >> 2), divisor s
  localparam int unsigned IDX_NW   = 23;
  localparam int unsigned IDX_DW   = 13;
  // dimming divider: numerator c << 8, divisor 25600 / power
  localparam int unsigned DIM_NW   = 16;
  localparam int unsigned DIM_DW   = 15;

  localparam int unsigned FULL_POWER   = 100;
  localparam int unsigned SPECTRUM_END = 638;

  // floor(m * 128 / 319) == floor((m << 8) / 638), exact for 14-bit m
  localparam logic [21:0] SPEC_RECIP = 22'd3365962;
  localparam int unsigned SPEC_SHIFT = 30;

  localparam logic [MAXD_W-1:0]  MAXD_RESET  = 14'd1000;
  localparam logic [POWER_W-1:0] POWER_RESET = 7'd50;

  typedef enum logic [0:0] {
    REG_MAX_DISTANCE = 1'b0,
    REG_DRIVE_POWER  = 1'b1
  } cfg_reg_e;

  function automatic logic [IDX_DW-1:0] calc_step(input logic [MAXD_W-1:0] m);
    logic [20:0]        y;
    logic [42:0]        p;
    logic [IDX_DW-1:0]  s;
    y = {m, 7'b0};
    p = 43'(y) * 43'(SPEC_RECIP);
    s = p[SPEC_SHIFT +: IDX_DW];
    if (s == '0) s = IDX_DW'(1);
    return s;
  endfunction

endpackage

### design/drc_div_cell.sv
`timescale 1ns / 1ps
module drc_div_cell #(
  parameter int unsigned NW    = 16,
  parameter int unsigned DW    = 15,
  parameter int unsigned LANES = 1
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic [DW-1:0]                  div_i,
  input  logic                           valid_i,
  input  logic                           tag_i,
  input  logic [LANES-1:0][DW-1:0]       rem_i,
  input  logic [LANES-1:0][NW-1:0]       nq_i,
  output logic                           valid_o,
  output logic                           tag_o,
  output logic [LANES-1:0][DW-1:0]       rem_o,
  output logic [LANES-1:0][NW-1:0]       nq_o
);

  logic [LANES-1:0][DW-1:0] rem_d;
  logic [LANES-1:0][NW-1:0] nq_d;

  // one restoring step per lane: bring down the next numerator bit
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic [DW:0] t;
      logic [DW:0] diff;
      logic        ge;
      t        = {rem_i[l], nq_i[l][NW-1]};
      diff     = t - {1'b0, div_i};
      ge       = (t >= {1'b0, div_i});
      rem_d[l] = ge ? diff[DW-1:0] : t[DW-1:0];
      nq_d[l]  = {nq_i[l][NW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else if (en_i) begin
      valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      tag_o <= tag_i;
      rem_o <= rem_d;
      nq_o  <= nq_d;
    end
  end

endmodule

### design/distance_to_rainbow_color_unit.sv
`timescale 1ns / 1ps
// Channel   | Direction | Payload
// s_axis    | in        | tdata[15:0] zone distance (mm), tdata[23:16] target_count
// m_axis    | out       | tdata[7:0] green, [15:8] red, [23:16] blue
// cfg       | in        | index 0 max_distance, index 1 drive_power
//
// One request enters per cycle while the output is not stalled; each result is
// presented through 41 register stages (one prep stage,
// 23 index divider cells, one color stage, 16 dimming cells).
// The whole row advances together; a result held at m_axis stalls the row and
// s_axis_tready drops. Reset clears valid bits and loads register defaults.
module distance_to_rainbow_color_unit import drc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [23:0]        s_axis_tdata,   // zone distance, target_count
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [23:0]        m_axis_tdata,   // green_level, red_level, blue_level
  input  logic               cfg_we_i,
  input  logic [0:0]         cfg_addr_i,
  input  logic [MAXD_W-1:0]  cfg_wdata_i
);

  // constant table of 25600 / p for p in 0..100 (entry 0 is picked only for power 0, whose results are blanked)
  logic [DIM_DW-1:0] q_tab [FULL_POWER+1];
  for (genvar i = 0; i <= FULL_POWER; i++) begin : g_qtab
    localparam int unsigned QV = (FULL_POWER * 256) / ((i == 0) ? 1 : i);
    assign q_tab[i] = DIM_DW'(QV);
  end

  // configuration registers plus their derived divisors
  logic [MAXD_W-1:0]  maxd_q;
  logic [POWER_W-1:0] power_q;
  logic [IDX_DW-1:0]  step_q;
  logic [DIM_DW-1:0]  q_q;
  logic [POWER_W-1:0] wpow;

  assign wpow = (cfg_wdata_i[POWER_W-1:0] > POWER_W'(FULL_POWER)) ?
                POWER_W'(FULL_POWER) : cfg_wdata_i[POWER_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxd_q  <= MAXD_RESET;
      step_q  <= calc_step(MAXD_RESET);
      power_q <= POWER_RESET;
      q_q     <= DIM_DW'((FULL_POWER * 256) / POWER_RESET);
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_addr_i))
        REG_MAX_DISTANCE: begin
          maxd_q <= cfg_wdata_i;
          step_q <= calc_step(cfg_wdata_i);
        end
        REG_DRIVE_POWER: begin
          power_q <= cfg_wdata_i[POWER_W-1:0];
          q_q     <= q_tab[wpow];
        end
        default: ;
      endcase
    end
  end

  // advance the whole row unless a result is held at the output
  logic en;
  assign en            = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // prep stage: subtract the offset, clip, form the rounded numerator
  logic [DIST_W-1:0]  zone_mm, dsub;
  logic [COUNT_W-1:0] cnt;
  logic [MAXD_W-1:0]  dclip;
  logic               prep_v_q, prep_blk_q;
  logic [IDX_NW-1:0]  prep_num_q;

  assign zone_mm = s_axis_tdata[DIST_W-1:0];
  assign cnt     = s_axis_tdata[DIST_W +: COUNT_W];
  assign dsub    = (zone_mm >= DIST_W'(2)) ? (zone_mm - DIST_W'(2)) : zone_mm;
  assign dclip   = (dsub > DIST_W'(maxd_q)) ? maxd_q : dsub[MAXD_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prep_v_q <= 1'b0;
    end else if (en) begin
      prep_v_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      prep_blk_q <= (cnt == '0) || (power_q == '0);
      prep_num_q <= {1'b0, dclip, 8'b0} + IDX_NW'(step_q >> 2);
    end
  end

  // index divider: one quotient bit per cell
  logic [IDX_NW:0]                    idx_v, idx_blk;
  logic [IDX_NW:0][0:0][IDX_DW-1:0]   idx_rem;
  logic [IDX_NW:0][0:0][IDX_NW-1:0]   idx_nq;

  assign idx_v[0]      = prep_v_q;
  assign idx_blk[0]    = prep_blk_q;
  assign idx_rem[0][0] = '0;
  assign idx_nq[0][0]  = prep_num_q;

  for (genvar k = 0; k < IDX_NW; k++) begin : g_idx
    drc_div_cell #(.NW(IDX_NW), .DW(IDX_DW), .LANES(1)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .div_i(step_q),
      .valid_i(idx_v[k]),   .tag_i(idx_blk[k]),
      .rem_i(idx_rem[k]),   .nq_i(idx_nq[k]),
      .valid_o(idx_v[k+1]), .tag_o(idx_blk[k+1]),
      .rem_o(idx_rem[k+1]), .nq_o(idx_nq[k+1])
    );
  end

  // color stage: three linear segments, black past the end of the spectrum
  logic [IDX_NW-1:0]  idx;
  logic [9:0]         i10;
  logic [LEVEL_W-1:0] r, g, b;
  logic               col_v_q, col_blk_q;
  logic [2:0][DIM_NW-1:0] col_num_q;

  assign idx = idx_nq[IDX_NW][0];
  assign i10 = idx[9:0];

  always_comb begin
    r = '0;
    g = '0;
    b = '0;
    if (idx < IDX_NW'(256)) begin
      r = LEVEL_W'(10'd255 - i10);
      g = i10[LEVEL_W-1:0];
    end else if (idx < IDX_NW'(511)) begin
      g = LEVEL_W'(10'd510 - i10);
      b = LEVEL_W'(i10 - 10'd255);
    end else if (idx < IDX_NW'(766)) begin
      r = LEVEL_W'(i10 - 10'd510);
      b = LEVEL_W'(10'd765 - i10);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_v_q <= 1'b0;
    end else if (en) begin
      col_v_q <= idx_v[IDX_NW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      col_blk_q    <= idx_blk[IDX_NW];
      col_num_q[0] <= {g, 8'b0};
      col_num_q[1] <= {r, 8'b0};
      col_num_q[2] <= {b, 8'b0};
    end
  end

  // dimming divider: three lanes side by side
  logic [DIM_NW:0]                  dim_v, dim_blk;
  logic [DIM_NW:0][2:0][DIM_DW-1:0] dim_rem;
  logic [DIM_NW:0][2:0][DIM_NW-1:0] dim_nq;

  assign dim_v[0]   = col_v_q;
  assign dim_blk[0] = col_blk_q;
  assign dim_rem[0] = '0;
  assign dim_nq[0]  = col_num_q;

  for (genvar k = 0; k < DIM_NW; k++) begin : g_dim
    drc_div_cell #(.NW(DIM_NW), .DW(DIM_DW), .LANES(3)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .div_i(q_q),
      .valid_i(dim_v[k]),   .tag_i(dim_blk[k]),
      .rem_i(dim_rem[k]),   .nq_i(dim_nq[k]),
      .valid_o(dim_v[k+1]), .tag_o(dim_blk[k+1]),
      .rem_o(dim_rem[k+1]), .nq_o(dim_nq[k+1])
    );
  end

  // last cell is the output register; drop color for zones without target or at zero drive power
  assign m_axis_tvalid = dim_v[DIM_NW];
  always_comb begin
    for (int l = 0; l < 3; l++) begin
      m_axis_tdata[l*LEVEL_W +: LEVEL_W] =
        dim_blk[DIM_NW] ? '0 : dim_nq[DIM_NW][l][LEVEL_W-1:0];
    end
  end

endmodule

### design/drc_checker.sv
`timescale 1ns / 1ps
module drc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_ready_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_ready_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input stalled while output drains");

endmodule

bind distance_to_rainbow_color_unit drc_checker u_drc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
